// ===== design/fixed_point_alu_defines.svh =====
// Assertion macros for the fixed-point ALU
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH
// a implies b on the same edge
`define FPA_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");
// a implies b at the next edge
`define FPA_ASSERT_NXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== design/fpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fpa_pkg: shared types and constants
// Operation codes, widths and the request record carried down the cell chain.
// ---------------------------------------------------------------------------
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int W = 32;
	localparam int QW = 2 * W;           // dividend width after prescale
	localparam int NCELL = QW;           // one quotient bit per cell

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MIN = 3'd4;
	localparam logic [2:0] OP_MAX = 3'd5;

	typedef struct packed {
		logic          vld;
		logic [2:0]    op;
		logic [W-1:0]  res;     // finished result for non-divide ops
		logic          neg;     // quotient sign
		logic          dz;
		logic          lt;
		logic          eq;
		logic          gt;
		logic [QW-1:0] num;     // dividend magnitude, shifted out one bit/cell
		logic [W-1:0]  den;     // divisor magnitude
		logic [W:0]    rem;     // partial remainder
		logic [QW-1:0] quo;     // quotient bits, shifted in one bit/cell
	} cell_t;
endpackage

// ===== design/fpa_front.sv =====
// ---------------------------------------------------------------------------
// fpa_front: operand decode stage
// Add/sub/min/max/compare, multiply, and divide setup into the first cell.
// ---------------------------------------------------------------------------
module fpa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [2:0]           op,
	input  logic signed [31:0]   a,
	input  logic signed [31:0]   b,
	output fpa_pkg::cell_t       cell_s1
);
	import fpa_pkg::*;
	logic signed [QW-1:0] prod;
	logic [W-1:0]  res;
	logic [W-1:0]  ma, mb;
	logic          lt;

	always_comb begin
		lt = a < b;
		prod = QW'(a) * QW'(b);
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
		case (op)
			OP_ADD:  res = W'(a + b);
			OP_SUB:  res = W'(a - b);
			OP_MUL:  res = W'(prod >>> FRAC_BITS);
			OP_MIN:  res = lt ? a : b;
			OP_MAX:  res = (a > b) ? a : b;
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else if (en) begin
			cell_s1.vld <= in_vld;
			cell_s1.op  <= op;
			cell_s1.res <= res;
			cell_s1.neg <= a[W-1] ^ b[W-1];
			cell_s1.dz  <= (op == OP_DIV) && (b == '0);
			cell_s1.lt  <= lt;
			cell_s1.eq  <= a == b;
			cell_s1.gt  <= a > b;
			cell_s1.num <= QW'(ma) << FRAC_BITS;
			cell_s1.den <= mb;
			cell_s1.rem <= '0;
			cell_s1.quo <= '0;
		end
	end
endmodule

// ===== design/fpa_cell.sv =====
// ---------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// Takes one dividend bit, forms one quotient bit, passes the record on.
// ---------------------------------------------------------------------------
module fpa_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  fpa_pkg::cell_t d,
	output fpa_pkg::cell_t q
);
	import fpa_pkg::*;
	logic [W:0] trial;
	logic [W:0] diff;
	logic       take;

	always_comb begin
		trial = {d.rem[W-1:0], d.num[QW-1]};
		diff  = trial - {1'b0, d.den};
		take  = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.vld <= d.vld;
			q.op  <= d.op;
			q.res <= d.res;
			q.neg <= d.neg;
			q.dz  <= d.dz;
			q.lt  <= d.lt;
			q.eq  <= d.eq;
			q.gt  <= d.gt;
			q.den <= d.den;
			q.num <= {d.num[QW-2:0], 1'b0};
			q.rem <= take ? diff : trial;
			q.quo <= {d.quo[QW-2:0], take};
		end
	end
endmodule

// ===== design/fixed_point_alu.sv =====
// ---------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point ALU
// Add, subtract, multiply, divide, min and max on 32-bit raw values.
// ---------------------------------------------------------------------------
//  channel | signals                                   | dir
//  request | req_valid req_ready req_type operand_a/b  | in
//  result  | res_valid res_ready result_value + flags  | out
//
// One request per cycle unless stalled. A request taken at one edge is loaded into the front
// stage at that edge, walks a chain of 64 divider cells (one quotient bit per
// cell) and lands in the output register.
// The whole chain moves together: it advances when the output register is
// empty or being taken, so a stall holds every stage in place.
// Reset clears all stage valid bits; no results are in flight after reset.
// ---------------------------------------------------------------------------
`include "fixed_point_alu_defines.svh"
module fixed_point_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                res_valid,
	input  logic                res_ready,
	output logic signed [31:0]  result_value,
	output logic                divide_by_zero,
	output logic                a_less,
	output logic                a_equal,
	output logic                a_greater
);
	import fpa_pkg::*;

	cell_t chain [NCELL+1];
	cell_t last;
	logic  en;
	logic [W-1:0] quo_w;
	logic [W-1:0] fin;

	// advance whenever the output slot is free or draining
	assign en = !res_valid || res_ready;
	assign req_ready = en;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(req_valid), .op(req_type),
		.a(operand_a), .b(operand_b),
		.cell_s1(chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fpa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.d(chain[i]), .q(chain[i+1])
		);
	end

	assign last = chain[NCELL];

	always_comb begin
		quo_w = last.quo[W-1:0];
		if (last.op == OP_DIV)
			fin = last.dz ? '0 : (last.neg ? W'(-quo_w) : quo_w);
		else
			fin = last.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value   <= fin;
			divide_by_zero <= last.dz;
			a_less         <= last.lt;
			a_equal        <= last.eq;
			a_greater      <= last.gt;
		end
	end

	// exactly one comparison flag on every result
	`FPA_ASSERT_IMP(a_flags_onehot, res_valid, $onehot({a_less, a_equal, a_greater}))
	// a stalled result holds
	`FPA_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(result_value))
	// zero-divide result is zero
	`FPA_ASSERT_IMP(a_dz_zero, res_valid && divide_by_zero, result_value == '0)
endmodule
